/* design/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table depth, field widths, command and status codes, cell control struct.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int ENTRIES = 32;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 64;
    localparam int QTY_W   = 32;
    localparam int TOT_W   = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_MARKED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EVAL,
        S_UPD
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
        logic             done;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             del;
        logic             mark;
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
    } cell_ctrl_t;

    // lookup result gathered from the cell row
    typedef struct packed {
        logic found;
        logic hit_done;
    } lookup_t;

endpackage

/* design/skt_cell.sv */
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one entry, compares it against the request key, and shifts toward
// either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module skt_cell (
    input  logic               aclk,
    input  skt_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  skt_pkg::entry_t    prev_entry,
    input  logic               prev_cond,
    input  skt_pkg::entry_t    next_entry,
    output skt_pkg::entry_t    entry,
    output logic               cond,
    output logic               hit,
    output logic               hit_done
);
    import skt_pkg::*;

    entry_t entry_reg, entry_next;
    logic   cond_reg, cond_next;
    logic   eq_reg, eq_next;
    logic   first;

    // first slot whose key is >= request key, or first free slot
    assign first    = cond_reg && !prev_cond;
    assign entry    = entry_reg;
    assign cond     = cond_reg;
    assign hit      = first && eq_reg;
    assign hit_done = first && eq_reg && entry_reg.done;

    always_comb begin
        entry_next = entry_reg;
        cond_next  = cond_reg;
        eq_next    = eq_reg;
        if (ctrl.cmp) begin
            cond_next = !occupied || (entry_reg.key >= ctrl.key);
            eq_next   = occupied && (entry_reg.key == ctrl.key);
        end
        if (ctrl.ins) begin
            if (first) begin
                entry_next.key  = ctrl.key;
                entry_next.qty  = ctrl.qty;
                entry_next.done = 1'b0;
            end else if (prev_cond) begin
                entry_next = prev_entry;
            end
        end
        if (ctrl.del && cond_reg) begin
            entry_next = next_entry;
        end
        if (ctrl.mark && first) begin
            entry_next.done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        cond_reg  <= cond_next;
        eq_reg    <= eq_next;
    end

endmodule

/* design/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// skt_ctrl: request sequencer for the sorted key table
// Latches a request, steps compare / evaluate / update, keeps the entry and
// done counts and holds the response register.
// ----------------------------------------------------------------------------
module skt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  skt_pkg::cmd_t              req_cmd,
    input  logic [skt_pkg::KEY_W-1:0]  req_key,
    input  logic [skt_pkg::QTY_W-1:0]  req_qty,
    input  skt_pkg::lookup_t           lookup,
    output skt_pkg::cell_ctrl_t        ctrl,
    output logic [skt_pkg::CNT_W-1:0]  count,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output skt_pkg::status_t           rsp_status,
    output logic [skt_pkg::TOT_W-1:0]  rsp_entry_total,
    output logic [skt_pkg::TOT_W-1:0]  rsp_done_total,
    output logic [skt_pkg::TOT_W-1:0]  rsp_open_total
);
    import skt_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [QTY_W-1:0]   qty_reg;
    lookup_t            lookup_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic               valid_reg, valid_next;
    status_t            status_reg, status_next;
    logic [TOT_W-1:0]   etot_reg, etot_next;
    logic [TOT_W-1:0]   dtot_reg, dtot_next;
    logic [TOT_W-1:0]   otot_reg, otot_next;
    logic [CNT_W-1:0]   open_cnt;
    logic               out_free;
    logic               accept;

    assign req_ready       = (state_reg == S_IDLE);
    assign accept          = req_valid && req_ready;
    assign out_free        = !valid_reg || rsp_ready;
    assign count           = count_reg;
    assign rsp_valid       = valid_reg;
    assign rsp_status      = status_reg;
    assign rsp_entry_total = etot_reg;
    assign rsp_done_total  = dtot_reg;
    assign rsp_open_total  = otot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= req_cmd;
            key_reg <= req_key;
            qty_reg <= req_qty;
        end
        if (state_reg == S_EVAL) begin
            lookup_reg <= lookup;
        end
        status_reg <= status_next;
        etot_reg   <= etot_next;
        dtot_reg   <= dtot_next;
        otot_reg   <= otot_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        etot_next   = etot_reg;
        dtot_next   = dtot_reg;
        otot_next   = otot_reg;
        open_cnt    = '0;
        ctrl.cmp    = 1'b0;
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        ctrl.mark   = 1'b0;
        ctrl.key    = key_reg;
        ctrl.qty    = qty_reg;

        if (valid_reg && rsp_ready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctrl.cmp   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    status_next = ST_OK;
                    unique case (cmd_reg)
                        CMD_INSERT: begin
                            if (count_reg == CNT_W'(ENTRIES)) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_MARK: begin
                            if (!lookup_reg.found) begin
                                status_next = ST_MISSING;
                            end else if (lookup_reg.hit_done) begin
                                status_next = ST_MARKED;
                            end else begin
                                ctrl.mark = 1'b1;
                                done_next = done_reg + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (!lookup_reg.found) begin
                                status_next = ST_MISSING;
                            end else begin
                                ctrl.del   = 1'b1;
                                count_next = count_reg - 1'b1;
                                if (lookup_reg.hit_done && done_reg != '0) begin
                                    done_next = done_reg - 1'b1;
                                end
                            end
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    open_cnt   = (count_next >= done_next) ? count_next - done_next : '0;
                    etot_next  = TOT_W'(count_next);
                    dtot_next  = TOT_W'(done_next);
                    otot_next  = TOT_W'(open_cnt);
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table: table of keyed entries kept in ascending key order
// Each request steps through accept, compare in every cell, gather the hit,
// and shift or mark in every cell before its response, held in the update
// step only while an earlier response is still waiting on m_tready. The row
// of cells compares all entries at once, so the time does not grow with the
// table size. Commands: insert (keeps order, equal keys go first), mark done,
// delete; each returns a status and the entry, done and open counts.
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command [1:0], key [65:2], quantity [97:66], zero fill to 104 bits
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status [1:0], entry_total [7:2], done_total [13:8], open_total [19:14]
    output logic [23:0]  m_tdata
);
    import skt_pkg::*;

    cell_ctrl_t         ctrl;
    lookup_t            lookup;
    logic [CNT_W-1:0]   count;
    entry_t             entries [ENTRIES];
    logic [ENTRIES-1:0] conds;
    logic [ENTRIES-1:0] hits;
    logic [ENTRIES-1:0] hit_dones;
    status_t            status;
    logic [TOT_W-1:0]   entry_total;
    logic [TOT_W-1:0]   done_total;
    logic [TOT_W-1:0]   open_total;

    assign lookup.found    = |hits;
    assign lookup.hit_done = |hit_dones;

    skt_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_cmd         (cmd_t'(s_tdata[1:0])),
        .req_key         (s_tdata[65:2]),
        .req_qty         (s_tdata[97:66]),
        .lookup          (lookup),
        .ctrl            (ctrl),
        .count           (count),
        .rsp_valid       (m_tvalid),
        .rsp_ready       (m_tready),
        .rsp_status      (status),
        .rsp_entry_total (entry_total),
        .rsp_done_total  (done_total),
        .rsp_open_total  (open_total)
    );

    assign m_tdata = {4'b0, open_total, done_total, entry_total, status};

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        entry_t prev_entry;
        entry_t next_entry;
        logic   prev_cond;
        logic   occupied;

        assign occupied = (CNT_W'(i) < count);

        if (i == 0) begin : g_head
            assign prev_entry = entries[i];
            assign prev_cond  = 1'b0;
        end else begin : g_body
            assign prev_entry = entries[i-1];
            assign prev_cond  = conds[i-1];
        end

        if (i == ENTRIES - 1) begin : g_tail
            assign next_entry = entries[i];
        end else begin : g_mid
            assign next_entry = entries[i+1];
        end

        skt_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .prev_entry (prev_entry),
            .prev_cond  (prev_cond),
            .next_entry (next_entry),
            .entry      (entries[i]),
            .cond       (conds[i]),
            .hit        (hits[i]),
            .hit_done   (hit_dones[i])
        );
    end

endmodule
